FILE: rtl/mdes_pkg.sv
`default_nettype none

package mdes_pkg;

	localparam int DEM_W = 32;
	localparam int FRAC_W = 17;

	localparam logic [13:0] YEAR_LIMIT = 14'd9999;
	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

	// y / 100 as (y * 5243) >> 19, exact for every 14-bit year
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam logic [6:0] CENTURY = 7'd100;

	// first count value of each division pass, counted down to zero (one quotient bit a cycle)
	localparam logic [4:0] SHARE_LAST = 5'd31;
	localparam logic [4:0] FRAC_LAST = 5'd15;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	// register indexes on the config port (byte address 8 * index)
	localparam logic [2:0] REG_JAN_FEB = 3'd0;
	localparam logic [2:0] REG_MAR_APR = 3'd1;
	localparam logic [2:0] REG_MAY_JUN = 3'd2;
	localparam logic [2:0] REG_JUL_AUG = 3'd3;
	localparam logic [2:0] REG_SEP_OCT = 3'd4;
	localparam logic [2:0] REG_NOV_DEC = 3'd5;

	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_APR = 4'd4;
	localparam logic [3:0] MON_JUN = 4'd6;
	localparam logic [3:0] MON_SEP = 4'd9;
	localparam logic [3:0] MON_NOV = 4'd11;
	localparam logic [3:0] MON_DEC = 4'd12;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_LEAP  = 11'b00000000010,
		ST_CHECK = 11'b00000000100,
		ST_PREP  = 11'b00000001000,
		ST_DIV1  = 11'b00000010000,
		ST_CAP   = 11'b00000100000,
		ST_ACC   = 11'b00001000000,
		ST_FSET  = 11'b00010000000,
		ST_DIV2  = 11'b00100000000,
		ST_FIN   = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} state_t;

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
		logic [4:0] len;
		if (m == MON_FEB) begin
			len = leap ? 5'd29 : 5'd28;
		end else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
			len = 5'd30;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/monthly_demand_extraction_step.sv
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+-----------------------------------------------
// request   | req_valid/req_ready  | action, flow, min_flow, start_year/month/day/sum
// response  | rsp_valid/rsp_ready  | extraction, downstream_flow, demand_fraction,
//           |                      | error_code
// config    | APB (psel/penable)   | 64-bit monthly demand pairs at 8 * index
//
// One item at a time. For a load or an invalid date, rsp_valid rises after the
// leap, check and output states; a daily step may also use one shared restoring
// divider that makes one quotient bit a cycle: 32 bits of daily share, then 16 bits
// of demand fraction. req_ready is high only while the sequencer is idle; a
// finished result waits in the output register, and a new item is taken meanwhile.
// Reset: date 2000-01-01, month sum and demands zero.

module monthly_demand_extraction_step
	import mdes_pkg::*;
#(
	parameter int FLOW_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire logic               action,
	input  wire logic [31:0]        flow,
	input  wire logic signed [31:0] min_flow,
	input  wire logic [13:0]        start_year,
	input  wire logic [3:0]         start_month,
	input  wire logic [4:0]         start_day,
	input  wire logic [31:0]        start_sum,

	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output logic [31:0]             extraction,
	output logic [31:0]             downstream_flow,
	output logic [FRAC_W-1:0]       demand_fraction,
	output logic                    error_code,

	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [5:0]         paddr,
	input  wire logic [63:0]        pwdata,
	output logic [63:0]             prdata,
	output logic                    pready
);

	// volumes never exceed the 32-bit inputs, so storage is the narrower width
	localparam int VW = (FLOW_BITS < 32) ? FLOW_BITS : 32;

	state_t state_q;

	logic [63:0] dem_jf_q, dem_ma_q, dem_mj_q, dem_ja_q, dem_so_q, dem_nd_q;

	logic [13:0]    cur_year_q;
	logic [3:0]     cur_month_q;
	logic [4:0]     cur_day_q;
	logic [VW-1:0]  month_sum_q;

	logic           act_q;
	logic [VW-1:0]  flow_q;
	logic [VW-1:0]  qmin_q;
	logic [7:0]     q100_q;
	logic [4:0]     mlen_q;
	logic [DEM_W-1:0] dem_q;
	logic [VW-1:0]  sum_eff_q;
	logic [VW-1:0]  e_q;
	logic [VW-1:0]  sum_new_q;
	logic [FRAC_W-1:0] frac_q;
	logic           err_q;

	logic [DEM_W-1:0] rem_q, quo_q, dvs_q;
	logic [4:0]     cnt_q;

	// ---------------- config port ----------------
	wire logic [2:0] reg_idx = paddr[5:3];
	wire logic cfg_wr = psel && penable && pwrite;

	assign pready = 1'b1;

	always_comb begin
		unique case (reg_idx)
			REG_JAN_FEB: prdata = dem_jf_q;
			REG_MAR_APR: prdata = dem_ma_q;
			REG_MAY_JUN: prdata = dem_mj_q;
			REG_JUL_AUG: prdata = dem_ja_q;
			REG_SEP_OCT: prdata = dem_so_q;
			REG_NOV_DEC: prdata = dem_nd_q;
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dem_jf_q <= '0;
			dem_ma_q <= '0;
			dem_mj_q <= '0;
			dem_ja_q <= '0;
			dem_so_q <= '0;
			dem_nd_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_JAN_FEB: dem_jf_q <= pwdata;
				REG_MAR_APR: dem_ma_q <= pwdata;
				REG_MAY_JUN: dem_mj_q <= pwdata;
				REG_JUL_AUG: dem_ja_q <= pwdata;
				REG_SEP_OCT: dem_so_q <= pwdata;
				REG_NOV_DEC: dem_nd_q <= pwdata;
				default: ;
			endcase
		end
	end

	// ---------------- combinational helpers ----------------
	logic [26:0]      year_prod;
	logic [13:0]      year_c100;
	logic             leap;
	logic [4:0]       mlen;
	logic             date_ok;
	logic [63:0]      dem_pair;
	logic [3:0]       mon_m1;
	logic [DEM_W-1:0] dem_sel;
	logic [4:0]       days_left;
	logic             no_take;
	logic [VW-1:0]    diff;
	logic [DEM_W:0]   rem_sh;
	logic             q_bit;
	logic [DEM_W-1:0] rem_next, quo_next;

	assign year_prod = 27'(cur_year_q) * 27'(DIV100_MUL);
	assign year_c100 = 14'(q100_q * CENTURY);
	assign leap = (cur_year_q[1:0] == 2'b00) &&
		((cur_year_q != year_c100) || (q100_q[1:0] == 2'b00));
	assign mlen = month_len(leap, cur_month_q);
	assign date_ok = (cur_year_q <= YEAR_LIMIT) && (cur_month_q != 4'd0) &&
		(cur_month_q <= MON_DEC) && (cur_day_q != 5'd0) && (cur_day_q <= mlen);

	assign mon_m1 = cur_month_q - 4'd1;
	always_comb begin
		unique case (mon_m1[3:1])
			3'd0:    dem_pair = dem_jf_q;
			3'd1:    dem_pair = dem_ma_q;
			3'd2:    dem_pair = dem_mj_q;
			3'd3:    dem_pair = dem_ja_q;
			3'd4:    dem_pair = dem_so_q;
			default: dem_pair = dem_nd_q;
		endcase
	end
	assign dem_sel = mon_m1[0] ? dem_pair[63:32] : dem_pair[31:0];

	assign days_left = mlen_q - cur_day_q + 5'd1;
	assign no_take = (DEM_W'(sum_eff_q) >= dem_q) || (flow_q <= qmin_q) ||
		(dem_q == '0);
	assign diff = flow_q - qmin_q;

	// restoring divider step: one quotient bit a cycle
	assign rem_sh = {rem_q, quo_q[DEM_W-1]};
	assign q_bit = rem_sh >= {1'b0, dvs_q};
	assign rem_next = q_bit ? DEM_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DEM_W-1:0];
	assign quo_next = {quo_q[DEM_W-2:0], q_bit};

	assign req_ready = (state_q == ST_IDLE);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_year_q  <= 14'd2000;
			cur_month_q <= 4'd1;
			cur_day_q   <= 5'd1;
			month_sum_q <= '0;
			rsp_valid   <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// in ST_OUT the output stage decides rsp_valid itself
			if (rsp_valid && rsp_ready && state_q != ST_OUT) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						act_q  <= action;
						flow_q <= flow[VW-1:0];
						qmin_q <= min_flow[31] ? '0 : min_flow[VW-1:0];
						if (action == ACT_LOAD) begin
							cur_year_q  <= start_year;
							cur_month_q <= start_month;
							cur_day_q   <= start_day;
							month_sum_q <= start_sum[VW-1:0];
						end
						state_q <= ST_LEAP;
					end
				end
				ST_LEAP: begin
					q100_q  <= year_prod[26:19];
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					mlen_q    <= mlen;
					dem_q     <= dem_sel;
					sum_eff_q <= (cur_day_q == 5'd1) ? '0 : month_sum_q;
					if (act_q == ACT_LOAD || !date_ok) begin
						err_q   <= !date_ok;
						e_q     <= '0;
						flow_q  <= '0;
						frac_q  <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (no_take) begin
						e_q     <= '0;
						state_q <= ST_ACC;
					end else begin
						rem_q   <= '0;
						quo_q   <= dem_q - DEM_W'(sum_eff_q);
						dvs_q   <= DEM_W'(days_left);
						cnt_q   <= SHARE_LAST;
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						state_q <= ST_CAP;
					end
				end
				ST_CAP: begin
					e_q     <= (quo_q > DEM_W'(diff)) ? diff : quo_q[VW-1:0];
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_new_q <= sum_eff_q + e_q;
					state_q   <= ST_FSET;
				end
				ST_FSET: begin
					if (dem_q == '0) begin
						frac_q  <= '0;
						state_q <= ST_FIN;
					end else if (DEM_W'(sum_new_q) >= dem_q) begin
						frac_q  <= FRAC_ONE;
						state_q <= ST_FIN;
					end else begin
						// sum < demand, so (sum << 16) / demand fits 16 bits
						rem_q   <= DEM_W'(sum_new_q);
						quo_q   <= '0;
						dvs_q   <= dem_q;
						cnt_q   <= FRAC_LAST;
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						frac_q  <= FRAC_W'(quo_next[15:0]);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					err_q   <= 1'b0;
					state_q <= ST_OUT;
					if (cur_day_q >= mlen_q) begin
						if (cur_month_q >= MON_DEC) begin
							if (cur_year_q >= YEAR_LIMIT) begin
								// end of calendar: report, keep the state
								err_q <= 1'b1;
							end else begin
								cur_year_q  <= cur_year_q + 14'd1;
								cur_month_q <= 4'd1;
								cur_day_q   <= 5'd1;
								month_sum_q <= sum_new_q;
							end
						end else begin
							cur_month_q <= cur_month_q + 4'd1;
							cur_day_q   <= 5'd1;
							month_sum_q <= sum_new_q;
						end
					end else begin
						cur_day_q   <= cur_day_q + 5'd1;
						month_sum_q <= sum_new_q;
					end
				end
				ST_OUT: begin
					if (!rsp_valid || rsp_ready) begin
						extraction      <= 32'(e_q);
						downstream_flow <= 32'(flow_q - e_q);
						demand_fraction <= frac_q;
						error_code      <= err_q;
						rsp_valid       <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
